@@ rtl/mnas_pkg.sv @@
// Shared types and constants for the MIDI note activity statistics block.
package mnas_pkg;

    localparam int CHANNELS_DEF     = 16;
    localparam int DRUM_CHANNEL_DEF = 9;
    localparam int NOTES            = 128;
    localparam int CH_W             = 4;
    localparam int NOTE_W           = 7;
    localparam int TIME_W           = 32;
    localparam int COUNT_W          = 32;
    localparam int TOTAL_W          = 12;
    localparam int CH_ACT_W         = 8;
    localparam int MASK_W           = 16;
    localparam int USED_W           = 5;
    localparam int FLAGS_W          = 64;
    localparam int IN_DATA_W        = 56;
    localparam int OUT_DATA_W       = 176;

    typedef enum logic [1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_ALL_OFF  = 2'd2,
        MODE_READ     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SEL_PROG_LO = 2'd0,
        SEL_PROG_HI = 2'd1,
        SEL_DRUM_LO = 2'd2,
        SEL_DRUM_HI = 2'd3
    } flag_sel_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // One event request as it is held while the row read is in flight.
    typedef struct packed {
        mode_t              mode;
        logic [CH_W-1:0]    channel;
        logic [NOTE_W-1:0]  note;
        logic [NOTE_W-1:0]  program_req;
        logic [TIME_W-1:0]  event_time;
        flag_sel_t          flag_word;
    } event_t;

    typedef struct packed {
        logic             we;
        logic [NOTES-1:0] data;
    } row_wr_t;

    typedef struct packed {
        logic [COUNT_W-1:0] notes_started;
        logic [TOTAL_W-1:0] active_now;
        logic [TOTAL_W-1:0] peak_active;
        logic [MASK_W-1:0]  channel_mask;
        logic [USED_W-1:0]  channels_used;
        logic [TIME_W-1:0]  last_time;
        logic [FLAGS_W-1:0] flags_data;
    } result_t;

endpackage

@@ rtl/midi_note_activity_stats.sv @@
// Top level of the MIDI note activity statistics block: control and stream ports.
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready. s_tuser carries the event mode
//   (note on, note off, all notes off, read flags); s_tdata carries channel,
//   note, program, event time and flag word select.
//   Every request produces exactly one result on m_tvalid/m_tready, carrying
//   the note-on count, active and peak totals, channel mask and its population,
//   the last event time and, for a flag read, the selected 64-bit flag word.
//   The request and its note map row read are registered; in the execute
//   state the row is written back and the result loaded into the output
//   register once it is free. No new request is accepted before that.
//   A finished result waits in the output register; the next request is still
//   accepted and its row read, and its update waits until the output is free.
//   Reset clears all statistics, the flag sets and the row valid bits, so the
//   note map reads as silent at once; no clearing pass is needed.
module midi_note_activity_stats #(
    parameter int CHANNELS     = mnas_pkg::CHANNELS_DEF,
    parameter int DRUM_CHANNEL = mnas_pkg::DRUM_CHANNEL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel, note, program_req, event_time, flag_word, zero pad
    input  logic [mnas_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // notes_started, active_now, peak_active, channel_mask, channels_used,
    // last_time, flags_data, zero pad
    output logic [mnas_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mnas_pkg::*;

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    state_t           state_reg, state_next;
    event_t           ev_reg;
    logic             m_valid_reg, m_valid_next;
    result_t          res_reg;
    result_t          res;
    row_wr_t          row_wr;
    logic [NOTES-1:0] row;
    logic             accept;
    logic             upd;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        upd          = 1'b0;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    upd          = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg.mode        <= mode_t'(s_tuser);
            ev_reg.channel     <= s_tdata[3:0];
            ev_reg.note        <= s_tdata[10:4];
            ev_reg.program_req <= s_tdata[17:11];
            ev_reg.event_time  <= s_tdata[49:18];
            ev_reg.flag_word   <= flag_sel_t'(s_tdata[51:50]);
        end
        if (upd)
        begin
            res_reg <= res;
        end
    end

    mnas_row_mem #(
        .CHANNELS (CHANNELS),
        .CH_AW    (CH_AW)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (s_tdata[CH_AW-1:0]),
        .rd_data (row),
        .wr_en   (upd && row_wr.we),
        .wr_addr (ev_reg.channel[CH_AW-1:0]),
        .wr_data (row_wr.data)
    );

    mnas_stats #(
        .CHANNELS     (CHANNELS),
        .DRUM_CHANNEL (DRUM_CHANNEL),
        .CH_AW        (CH_AW)
    ) u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .ev     (ev_reg),
        .row    (row),
        .upd    (upd),
        .row_wr (row_wr),
        .res    (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000,
                       res_reg.flags_data,
                       res_reg.last_time,
                       res_reg.channels_used,
                       res_reg.channel_mask,
                       res_reg.peak_active,
                       res_reg.active_now,
                       res_reg.notes_started};

endmodule

@@ rtl/mnas_row_mem.sv @@
// Note map memory: one 128-bit row per channel, registered read, row valid bits.
module mnas_row_mem #(
    parameter int CHANNELS = mnas_pkg::CHANNELS_DEF,
    parameter int CH_AW    = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [CH_AW-1:0]           rd_addr,
    output logic [mnas_pkg::NOTES-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [CH_AW-1:0]           wr_addr,
    input  logic [mnas_pkg::NOTES-1:0] wr_data
);
    import mnas_pkg::*;

    logic [NOTES-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] row_valid_reg;
    logic [NOTES-1:0]    rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A row never written since reset reads as all silent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/mnas_stats.sv @@
// Event update logic: counters, peak, channel mask, flag sets and the row rewrite.
module mnas_stats #(
    parameter int CHANNELS     = mnas_pkg::CHANNELS_DEF,
    parameter int DRUM_CHANNEL = mnas_pkg::DRUM_CHANNEL_DEF,
    parameter int CH_AW        = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mnas_pkg::event_t           ev,
    input  logic [mnas_pkg::NOTES-1:0] row,
    input  logic                       upd,
    output mnas_pkg::row_wr_t          row_wr,
    output mnas_pkg::result_t          res
);
    import mnas_pkg::*;

    logic [CH_ACT_W-1:0] ch_act_reg [CHANNELS];
    logic [CH_ACT_W-1:0] ch_act_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [TOTAL_W-1:0]  peak_reg, peak_next;
    logic [COUNT_W-1:0]  started_reg, started_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [CHANNELS-1:0] used_reg, used_next;
    logic [USED_W-1:0]   used_cnt_reg, used_cnt_next;
    logic [NOTES-1:0]    prog_reg, prog_next;
    logic [NOTES-1:0]    drum_reg, drum_next;
    logic [FLAGS_W-1:0]  flags;

    logic [CH_AW-1:0]    ci;
    logic                ok;
    logic                was;
    logic [CH_ACT_W-1:0] cur_act;

    assign ci      = ev.channel[CH_AW-1:0];
    assign ok      = {1'b0, ev.channel} < (CH_W+1)'(CHANNELS);
    assign was     = row[ev.note];
    assign cur_act = ch_act_reg[ci];

    always_comb
    begin
        ch_act_next   = cur_act;
        total_next    = total_reg;
        peak_next     = peak_reg;
        started_next  = started_reg;
        time_next     = time_reg;
        used_next     = used_reg;
        used_cnt_next = used_cnt_reg;
        prog_next     = prog_reg;
        drum_next     = drum_reg;
        flags         = '0;
        row_wr.we     = 1'b0;
        row_wr.data   = row;

        unique case (ev.mode)
            MODE_NOTE_ON:
            begin
                if (ok)
                begin
                    used_next[ci] = 1'b1;
                    if (!used_reg[ci])
                    begin
                        used_cnt_next = used_cnt_reg + USED_W'(1);
                    end
                    // A repeat of a sounding note with the same time as the last event is dropped.
                    if (!(was && time_reg == ev.event_time))
                    begin
                        if (!was)
                        begin
                            row_wr.we             = 1'b1;
                            row_wr.data[ev.note]  = 1'b1;
                            ch_act_next           = cur_act + CH_ACT_W'(1);
                            total_next            = total_reg + TOTAL_W'(1);
                        end
                        if (ev.channel == CH_W'(DRUM_CHANNEL))
                        begin
                            drum_next[ev.note] = 1'b1;
                        end
                        else
                        begin
                            prog_next[ev.program_req] = 1'b1;
                        end
                        time_next = ev.event_time;
                        if (peak_reg < total_next)
                        begin
                            peak_next = total_next;
                        end
                        if (started_reg != '1)
                        begin
                            started_next = started_reg + COUNT_W'(1);
                        end
                    end
                end
            end
            MODE_NOTE_OFF:
            begin
                if (ok)
                begin
                    time_next = ev.event_time;
                    if (was)
                    begin
                        row_wr.we            = 1'b1;
                        row_wr.data[ev.note] = 1'b0;
                        ch_act_next          = cur_act - CH_ACT_W'(1);
                        total_next           = total_reg - TOTAL_W'(1);
                    end
                end
            end
            MODE_ALL_OFF:
            begin
                if (ok)
                begin
                    // The channel count equals the number of set bits in its row.
                    row_wr.we   = 1'b1;
                    row_wr.data = '0;
                    ch_act_next = '0;
                    total_next  = total_reg - TOTAL_W'(cur_act);
                end
            end
            MODE_READ:
            begin
                unique case (ev.flag_word)
                    SEL_PROG_LO: flags = prog_reg[FLAGS_W-1:0];
                    SEL_PROG_HI: flags = prog_reg[NOTES-1:FLAGS_W];
                    SEL_DRUM_LO: flags = drum_reg[FLAGS_W-1:0];
                    SEL_DRUM_HI: flags = drum_reg[NOTES-1:FLAGS_W];
                    default:     flags = '0;
                endcase
            end
            default:
            begin
                flags = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ch_act_reg[i] <= '0;
            end
            total_reg    <= '0;
            peak_reg     <= '0;
            started_reg  <= '0;
            time_reg     <= '0;
            used_reg     <= '0;
            used_cnt_reg <= '0;
            prog_reg     <= '0;
            drum_reg     <= '0;
        end
        else if (upd)
        begin
            if (ok)
            begin
                ch_act_reg[ci] <= ch_act_next;
            end
            total_reg    <= total_next;
            peak_reg     <= peak_next;
            started_reg  <= started_next;
            time_reg     <= time_next;
            used_reg     <= used_next;
            used_cnt_reg <= used_cnt_next;
            prog_reg     <= prog_next;
            drum_reg     <= drum_next;
        end
    end

    assign res.notes_started = started_next;
    assign res.active_now    = total_next;
    assign res.peak_active   = peak_next;
    assign res.channel_mask  = MASK_W'(used_next);
    assign res.channels_used = used_cnt_next;
    assign res.last_time     = time_next;
    assign res.flags_data    = flags;

endmodule
